// ===== rtl/bsp_pkg.sv =====
// Shared types, constants and lookup functions for the byte-size text parser.
package bsp_pkg;

  localparam int unsigned MAX_STRING_LENGTH = 65535;
  localparam int IDX_W    = $clog2(MAX_STRING_LENGTH + 1);
  localparam int CHAR_W   = 8;
  localparam int TOTAL_W  = 64;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 16;
  localparam int MULT_W   = 28;
  localparam int HALF_W   = 32;
  localparam int PART_W   = HALF_W + MULT_W;
  localparam int SHIFT_W  = 6;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam int PEND_W     = FIFO_CW + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_DIGITS  = 2'd1,
    ST_BAD_SUFFIX = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_K  = 8'h6b;
  localparam logic [CHAR_W-1:0] CH_UP_K  = 8'h4b;
  localparam logic [CHAR_W-1:0] CH_LO_M  = 8'h6d;
  localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4d;
  localparam logic [CHAR_W-1:0] CH_LO_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_UP_G  = 8'h47;
  localparam logic [CHAR_W-1:0] CH_LO_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_UP_T  = 8'h54;

  localparam logic [TOTAL_W-1:0] MAG_LIMIT   = 64'h8000_0000_0000_0000;
  localparam logic [TOTAL_W-1:0] MAG_BIG     = 64'h8000_0000_0000_0001;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [TOTAL_W-1:0] TOTAL_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [TOTAL_W-1:0] DIGIT_BOUND = MAG_LIMIT / 10;

  localparam logic [TOTAL_W-1:0] BOUND_K_DEC = MAG_LIMIT / 64'd1000;
  localparam logic [TOTAL_W-1:0] BOUND_M_DEC = MAG_LIMIT / 64'd1000000;
  localparam logic [TOTAL_W-1:0] BOUND_G_DEC = MAG_LIMIT / 64'd1000000000;
  localparam logic [TOTAL_W-1:0] BOUND_T_DEC = MAG_LIMIT / 64'd1000000000000;
  localparam logic [TOTAL_W-1:0] BOUND_K_BIN = MAG_LIMIT / 64'd1024;
  localparam logic [TOTAL_W-1:0] BOUND_M_BIN = MAG_LIMIT / 64'd1048576;
  localparam logic [TOTAL_W-1:0] BOUND_G_BIN = MAG_LIMIT / 64'd1073741824;
  localparam logic [TOTAL_W-1:0] BOUND_T_BIN = MAG_LIMIT / 64'd1099511627776;

  // Scale is 1000^power (decimal) or 1024^power (binary); power 0 means unscaled.
  typedef struct packed {
    logic       valid;
    logic       binary;
    logic [2:0] power;
  } suffix_t;

  // Parser to arithmetic: one event per accepted character.
  typedef struct packed {
    logic                term;
    logic                emit;
    logic                err;
    status_t             err_status;
    logic [POS_W-1:0]    err_pos;
    logic                eos;
    logic                neg;
    suffix_t             sfx;
    logic [TOTAL_W-1:0]  accum;
  } event_t;

  typedef struct packed {
    logic                valid;
    logic [TOTAL_W-1:0]  total;
    status_t             status;
    logic [POS_W-1:0]    pos;
  } result_t;

  function automatic suffix_t suffix_decode(input logic [CHAR_W-1:0] c);
    suffix_t s;
    s = '0;
    s.valid = 1'b1;
    case (c)
      CH_LO_K: s.power = 3'd1;
      CH_LO_M: s.power = 3'd2;
      CH_LO_G: s.power = 3'd3;
      CH_LO_T: s.power = 3'd4;
      CH_UP_K: begin s.power = 3'd1; s.binary = 1'b1; end
      CH_UP_M: begin s.power = 3'd2; s.binary = 1'b1; end
      CH_UP_G: begin s.power = 3'd3; s.binary = 1'b1; end
      CH_UP_T: begin s.power = 3'd4; s.binary = 1'b1; end
      default: s.valid = 1'b0;
    endcase
    return s;
  endfunction

  // Odd factor of the scale: 1000^n = 125^n * 2^(3n).
  function automatic logic [MULT_W-1:0] scale_mult(input suffix_t s);
    logic [MULT_W-1:0] m;
    m = MULT_W'(1);
    if (!s.binary) begin
      case (s.power)
        3'd1:    m = MULT_W'(125);
        3'd2:    m = MULT_W'(15625);
        3'd3:    m = MULT_W'(1953125);
        3'd4:    m = MULT_W'(244140625);
        default: m = MULT_W'(1);
      endcase
    end
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] scale_shift(input suffix_t s);
    logic [SHIFT_W-1:0] sh;
    case (s.power)
      3'd1:    sh = s.binary ? SHIFT_W'(10) : SHIFT_W'(3);
      3'd2:    sh = s.binary ? SHIFT_W'(20) : SHIFT_W'(6);
      3'd3:    sh = s.binary ? SHIFT_W'(30) : SHIFT_W'(9);
      3'd4:    sh = s.binary ? SHIFT_W'(40) : SHIFT_W'(12);
      default: sh = '0;
    endcase
    return sh;
  endfunction

  // Largest magnitude that can be scaled without passing the signed limit.
  function automatic logic [TOTAL_W-1:0] scale_bound(input suffix_t s);
    logic [TOTAL_W-1:0] b;
    case (s.power)
      3'd1:    b = s.binary ? BOUND_K_BIN : BOUND_K_DEC;
      3'd2:    b = s.binary ? BOUND_M_BIN : BOUND_M_DEC;
      3'd3:    b = s.binary ? BOUND_G_BIN : BOUND_G_DEC;
      3'd4:    b = s.binary ? BOUND_T_BIN : BOUND_T_DEC;
      default: b = MAG_LIMIT;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/bsp_if.sv =====
// Stream interfaces for the character input and the parse result output.
interface bsp_char_if;
  logic                         valid;
  logic                         ready;
  logic [bsp_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface bsp_result_if;
  logic                          valid;
  logic                          ready;
  logic [bsp_pkg::TOTAL_W-1:0]   total_bytes;
  logic [bsp_pkg::STATUS_W-1:0]  status;
  logic [bsp_pkg::POS_W-1:0]     error_position;

  modport source (output valid, output total_bytes, output status, output error_position,
                  input ready);
  modport sink   (input valid, input total_bytes, input status, input error_position,
                  output ready);
endinterface

// ===== rtl/bsp_parse.sv =====
// Character front end: phase machine, digit accumulation and term events.
module bsp_parse import bsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [CHAR_W-1:0] char_code,
  output event_t            ev
);

  typedef enum logic [4:0] {
    PH_EXPECT = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_AFTER  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  phase_t             phase, phase_next;
  logic [TOTAL_W-1:0] accum, accum_next;
  logic               neg, neg_next;
  logic               have_term, have_term_next;
  logic [IDX_W-1:0]   term_start, term_start_next;
  logic [IDX_W-1:0]   idx, idx_next;
  event_t             ev_next;

  logic               digit;
  logic               space;
  logic               eos;
  suffix_t            sfx;
  logic [TOTAL_W-1:0] digit_val;
  logic [TOTAL_W-1:0] accum_step;
  logic [TOTAL_W-1:0] accum_digit;

  assign digit     = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign space     = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign eos       = (char_code == CH_NUL);
  assign sfx       = suffix_decode(char_code);
  assign digit_val = TOTAL_W'(char_code - CH_ZERO);

  // accum * 10 + digit, saturating to the oversize marker
  assign accum_step = (accum << 3) + (accum << 1) + digit_val;
  always_comb begin
    if (accum > DIGIT_BOUND || accum_step > MAG_LIMIT) begin
      accum_digit = MAG_BIG;
    end else begin
      accum_digit = accum_step;
    end
  end

  always_comb begin
    phase_next      = phase;
    accum_next      = accum;
    neg_next        = neg;
    have_term_next  = have_term;
    term_start_next = term_start;
    idx_next        = idx;
    ev_next         = '0;
    if (take) begin
      ev_next.eos        = eos;
      ev_next.accum      = accum;
      ev_next.neg        = neg;
      ev_next.err_status = ST_NO_DIGITS;
      ev_next.err_pos    = POS_W'(idx);
      unique case (phase)
        PH_EXPECT: begin
          if (space) begin
            phase_next = PH_EXPECT;
          end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
            term_start_next = idx;
            neg_next        = (char_code == CH_MINUS);
            accum_next      = '0;
            phase_next      = PH_SIGN;
          end else if (digit) begin
            term_start_next = idx;
            neg_next        = 1'b0;
            accum_next      = digit_val;
            phase_next      = PH_DIGITS;
          end else begin
            ev_next.emit = 1'b1;
            ev_next.err  = !have_term;
            phase_next   = PH_DONE;
          end
        end
        PH_SIGN: begin
          if (digit) begin
            accum_next = digit_val;
            phase_next = PH_DIGITS;
          end else begin
            ev_next.emit    = 1'b1;
            ev_next.err     = !have_term;
            ev_next.err_pos = POS_W'(term_start);
            phase_next      = PH_DONE;
          end
        end
        PH_DIGITS, PH_AFTER: begin
          if (phase == PH_DIGITS && digit) begin
            accum_next = accum_digit;
          end else if (eos) begin
            ev_next.term   = 1'b1;
            ev_next.emit   = 1'b1;
            have_term_next = 1'b1;
            phase_next     = PH_DONE;
          end else if (space) begin
            phase_next = PH_AFTER;
          end else if (sfx.valid) begin
            ev_next.term   = 1'b1;
            ev_next.sfx    = sfx;
            have_term_next = 1'b1;
            accum_next     = '0;
            neg_next       = 1'b0;
            phase_next     = PH_EXPECT;
          end else begin
            ev_next.emit       = 1'b1;
            ev_next.err        = 1'b1;
            ev_next.err_status = ST_BAD_SUFFIX;
            phase_next         = PH_DONE;
          end
        end
        PH_DONE: phase_next = PH_DONE;
        default: phase_next = PH_DONE;
      endcase
      // end of string returns everything to the start
      if (eos) begin
        phase_next      = PH_EXPECT;
        accum_next      = '0;
        neg_next        = 1'b0;
        have_term_next  = 1'b0;
        term_start_next = '0;
        idx_next        = '0;
      end else if (idx < IDX_W'(MAX_STRING_LENGTH)) begin
        idx_next = idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_EXPECT;
      accum      <= '0;
      neg        <= 1'b0;
      have_term  <= 1'b0;
      term_start <= '0;
      idx        <= '0;
      ev         <= '0;
    end else begin
      phase      <= phase_next;
      accum      <= accum_next;
      neg        <= neg_next;
      have_term  <= have_term_next;
      term_start <= term_start_next;
      idx        <= idx_next;
      ev         <= ev_next;
    end
  end

endmodule

// ===== rtl/bsp_sum.sv =====
// Term scaling, saturation and the running total, three register stages.
module bsp_sum import bsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  event_t      ev,
  output result_t     res,
  output logic [1:0]  inflight
);

  typedef struct packed {
    logic                term;
    logic                emit;
    logic                err;
    status_t             err_status;
    logic [POS_W-1:0]    err_pos;
    logic                eos;
    logic                neg;
    logic                big;
    logic [SHIFT_W-1:0]  shift;
    logic [PART_W-1:0]   hi_p;
    logic [PART_W-1:0]   lo_p;
  } prod_t;

  typedef struct packed {
    logic                term;
    logic                emit;
    logic                err;
    status_t             err_status;
    logic [POS_W-1:0]    err_pos;
    logic                eos;
    logic                ovf;
    logic [TOTAL_W-1:0]  value;
  } term_t;

  prod_t              pr, pr_next;
  term_t              tm, tm_next;
  logic [TOTAL_W-1:0] running_total, running_total_next;
  logic               overflowed, overflowed_next;

  logic [MULT_W-1:0]  mult;
  logic [TOTAL_W-1:0] prod_raw;
  logic [TOTAL_W-1:0] prod;
  logic [TOTAL_W-1:0] lim;
  logic [TOTAL_W-1:0] sum;
  logic               add_ovf;

  // Stage 1: split the 64-bit magnitude into two 32 x 28 partial products
  assign mult = scale_mult(ev.sfx);
  always_comb begin
    pr_next.term       = ev.term;
    pr_next.emit       = ev.emit;
    pr_next.err        = ev.err;
    pr_next.err_status = ev.err_status;
    pr_next.err_pos    = ev.err_pos;
    pr_next.eos        = ev.eos;
    pr_next.neg        = ev.neg;
    pr_next.big        = ev.accum > scale_bound(ev.sfx);
    pr_next.shift      = scale_shift(ev.sfx);
    pr_next.hi_p       = PART_W'(ev.accum[TOTAL_W-1:HALF_W]) * PART_W'(mult);
    pr_next.lo_p       = PART_W'(ev.accum[HALF_W-1:0]) * PART_W'(mult);
  end

  // Stage 2: combine, apply the power-of-two part, clamp to the signed range
  assign prod_raw = (TOTAL_W'(pr.hi_p) << HALF_W) + TOTAL_W'(pr.lo_p);
  assign prod     = pr.big ? MAG_BIG : (prod_raw << pr.shift);
  assign lim      = pr.neg ? MAG_LIMIT : (MAG_LIMIT - TOTAL_W'(1));
  always_comb begin
    tm_next.term       = pr.term;
    tm_next.emit       = pr.emit;
    tm_next.err        = pr.err;
    tm_next.err_status = pr.err_status;
    tm_next.err_pos    = pr.err_pos;
    tm_next.eos        = pr.eos;
    tm_next.ovf        = prod > lim;
    if (prod > lim) begin
      tm_next.value = pr.neg ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      tm_next.value = pr.neg ? (~prod + TOTAL_W'(1)) : prod;
    end
  end

  // Stage 3: saturating add into the running total and form the result
  assign sum     = running_total + tm.value;
  assign add_ovf = (running_total[TOTAL_W-1] == tm.value[TOTAL_W-1]) &&
                   (sum[TOTAL_W-1] != running_total[TOTAL_W-1]);
  always_comb begin
    running_total_next = running_total;
    overflowed_next    = overflowed;
    if (tm.term) begin
      if (add_ovf) begin
        running_total_next = tm.value[TOTAL_W-1] ? TOTAL_MIN : TOTAL_MAX;
      end else begin
        running_total_next = sum;
      end
      overflowed_next = overflowed | tm.ovf | add_ovf;
    end
  end

  always_comb begin
    res.valid = tm.emit;
    if (tm.err) begin
      res.total  = '1;
      res.status = tm.err_status;
      res.pos    = tm.err_pos;
    end else begin
      res.total  = running_total_next;
      res.status = overflowed_next ? ST_OVERFLOW : ST_OK;
      res.pos    = '0;
    end
  end

  assign inflight = 2'(pr.emit) + 2'(tm.emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      pr            <= '0;
      tm            <= '0;
      running_total <= '0;
      overflowed    <= 1'b0;
    end else begin
      pr <= pr_next;
      tm <= tm_next;
      if (tm.eos) begin
        running_total <= '0;
        overflowed    <= 1'b0;
      end else begin
        running_total <= running_total_next;
        overflowed    <= overflowed_next;
      end
    end
  end

endmodule

// ===== rtl/byte_size_text_parser_core.sv =====
// Byte-size text parser: takes one character per cycle while ready is high and
// sums terms such as "12k+3M" into a 64-bit byte count, one result per string
// ended by code 0. Throughput is one character every clock while ready is high.
// A result passes the input register, phase machine, partial products of the
// scale multiply, clamp to the signed range, and the saturating add into the
// running total before it enters the output queue. Results wait in an
// eight-entry queue; ready falls only when that queue together with the
// results still in the pipeline could fill it.
module byte_size_text_parser_core import bsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  bsp_char_if.sink      chars,
  bsp_result_if.source  results
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  event_t            ev;
  result_t           res;
  logic [1:0]        inflight;

  result_t           fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [PEND_W-1:0]  pending;
  logic               push;
  logic               pop;

  // every transaction still in flight may yet claim one queue slot
  assign pending = PEND_W'(count) + PEND_W'(in_valid) + PEND_W'(ev.emit) + PEND_W'(inflight);
  assign chars.ready = (pending < PEND_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= chars.valid && chars.ready;
    end
    in_char <= chars.char_code;
  end

  bsp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (in_valid),
    .char_code (in_char),
    .ev        (ev)
  );

  bsp_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .res      (res),
    .inflight (inflight)
  );

  assign push = res.valid;
  assign pop  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign results.valid          = (count != '0);
  assign results.total_bytes    = fifo_mem[rd_ptr].total;
  assign results.status         = fifo_mem[rd_ptr].status;
  assign results.error_position = fifo_mem[rd_ptr].pos;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the byte-size text parser: directed, long-string, back-pressure and random strings.
`timescale 1ns / 1ps

module tb_top;
  import bsp_pkg::*;

  typedef enum logic [2:0] {
    P_SEEK,
    P_SIGNED,
    P_IN_DIGITS,
    P_TRAILING,
    P_FINISHED
  } parse_phase_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    status_t            status;
    logic [POS_W-1:0]   pos;
  } size_result_t;

  localparam logic [7:0] ASCII_NUL   = 8'd0;
  localparam logic [7:0] ASCII_TAB   = 8'd9;
  localparam logic [7:0] ASCII_CR    = 8'd13;
  localparam logic [7:0] ASCII_SPACE = 8'd32;
  localparam logic [7:0] ASCII_PLUS  = "+";
  localparam logic [7:0] ASCII_MINUS = "-";
  localparam logic [7:0] ASCII_ZERO  = "0";
  localparam logic [7:0] ASCII_NINE  = "9";

  localparam logic [63:0] SAT_MAG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_BIG = 64'h8000_0000_0000_0001;
  localparam logic [63:0] I64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_RUN     = 200;

  logic clk;
  logic rst;
  int   hold_count = 0;

  bsp_char_if   chars ();
  bsp_result_if results ();

  byte_size_text_parser_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  // Predictor state
  parse_phase_t       parse_phase;
  logic [63:0]        mag;
  logic               minus;
  logic signed [63:0] sum;
  logic               got_term;
  int                 term_pos;
  int                 char_pos;
  logic               sat_flag;

  size_result_t expected_sizes[$];
  logic [7:0]   text_buf[$];
  int           errors;
  int           useful_chars;
  bit           paced;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_parse();
    parse_phase = P_SEEK;
    mag         = '0;
    minus       = 1'b0;
    sum         = '0;
    got_term    = 1'b0;
    term_pos    = 0;
    char_pos    = 0;
    sat_flag    = 1'b0;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ASCII_SPACE || (c >= ASCII_TAB && c <= ASCII_CR);
  endfunction

  function automatic logic [63:0] suffix_factor(input logic [7:0] c);
    case (c)
      "k":     return 64'd1000;
      "K":     return 64'd1024;
      "m":     return 64'd1000000;
      "M":     return 64'd1048576;
      "g":     return 64'd1000000000;
      "G":     return 64'd1073741824;
      "t":     return 64'd1000000000000;
      "T":     return 64'd1099511627776;
      default: return 64'd0;
    endcase
  endfunction

  function automatic void push_size(input logic [63:0] total, input status_t st,
                                    input int pos);
    size_result_t r;
    r.total  = total;
    r.status = st;
    r.pos    = pos[POS_W-1:0];
    expected_sizes.push_back(r);
  endfunction

  function automatic void push_success();
    push_size(sum, sat_flag ? ST_OVERFLOW : ST_OK, 0);
  endfunction

  // Scale the current number and add it to the total, saturating both steps.
  function automatic void add_scaled(input logic [63:0] factor);
    logic [63:0]        prod;
    logic [63:0]        lim;
    logic signed [63:0] term;
    logic signed [63:0] s;
    lim = minus ? SAT_MAG : SAT_MAG - 64'd1;
    if (mag > SAT_MAG / factor) prod = SAT_BIG;
    else prod = mag * factor;
    if (prod > lim) begin
      sat_flag = 1'b1;
      term = minus ? I64_MIN : I64_MAX;
    end else if (minus) begin
      term = -prod;
    end else begin
      term = prod;
    end
    s = sum + term;
    if (sum[63] == term[63] && s[63] != sum[63]) begin
      sat_flag = 1'b1;
      s = term[63] ? I64_MIN : I64_MAX;
    end
    sum      = s;
    got_term = 1'b1;
  endfunction

  function automatic void advance_size_parse(input logic [7:0] c);
    int          idx;
    bit          digit;
    logic [63:0] d;
    idx   = char_pos;
    digit = c >= ASCII_ZERO && c <= ASCII_NINE;
    d     = 64'(c - ASCII_ZERO);
    case (parse_phase)
      P_SEEK: begin
        if (is_blank(c)) begin
        end else if (c == ASCII_PLUS || c == ASCII_MINUS) begin
          term_pos    = idx;
          minus       = (c == ASCII_MINUS);
          mag         = '0;
          parse_phase = P_SIGNED;
        end else if (digit) begin
          term_pos    = idx;
          minus       = 1'b0;
          mag         = d;
          parse_phase = P_IN_DIGITS;
        end else begin
          if (got_term) push_success();
          else push_size(I64_MAX + I64_MAX + 64'd1, ST_NO_DIGITS, idx);
          parse_phase = P_FINISHED;
        end
      end
      P_SIGNED: begin
        if (digit) begin
          mag         = d;
          parse_phase = P_IN_DIGITS;
        end else begin
          if (got_term) push_success();
          else push_size({64{1'b1}}, ST_NO_DIGITS, term_pos);
          parse_phase = P_FINISHED;
        end
      end
      P_IN_DIGITS, P_TRAILING: begin
        if (parse_phase == P_IN_DIGITS && digit) begin
          if (mag > SAT_MAG / 64'd10) begin
            mag = SAT_BIG;
          end else begin
            mag = mag * 64'd10 + d;
            if (mag > SAT_MAG) mag = SAT_BIG;
          end
        end else if (c == ASCII_NUL) begin
          add_scaled(64'd1);
          push_success();
          parse_phase = P_FINISHED;
        end else if (is_blank(c)) begin
          parse_phase = P_TRAILING;
        end else if (suffix_factor(c) != 64'd0) begin
          add_scaled(suffix_factor(c));
          mag         = '0;
          minus       = 1'b0;
          parse_phase = P_SEEK;
        end else begin
          push_size({64{1'b1}}, ST_BAD_SUFFIX, idx);
          parse_phase = P_FINISHED;
        end
      end
      default: parse_phase = P_FINISHED;
    endcase
    if (c == ASCII_NUL) clear_parse();
    else if (char_pos < MAX_STRING_LENGTH) char_pos++;
  endfunction

  task automatic compare_size_result();
    size_result_t want;
    if (expected_sizes.size() == 0) begin
      $error("unexpected result: total_bytes %0d status %0d error_position %0d",
             $signed(results.total_bytes), results.status, results.error_position);
      errors++;
    end else begin
      want = expected_sizes.pop_front();
      if (results.total_bytes !== want.total) begin
        $error("total_bytes: expected %0d, got %0d", $signed(want.total),
               $signed(results.total_bytes));
        errors++;
      end
      if (results.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, results.status);
        errors++;
      end
      if (results.error_position !== want.pos) begin
        $error("error_position: expected %0d, got %0d", want.pos,
               results.error_position);
        errors++;
      end
    end
  endtask

  // Result side: check each transaction and stall on a changing pattern.
  initial begin
    int   stall_mode;
    int   mode_left;
    int   hold_left;
    int   hold_seen;
    int   tick;
    logic rdy;
    stall_mode = 0;
    mode_left  = 0;
    hold_left  = 0;
    hold_seen  = 0;
    tick       = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!rst && results.valid && results.ready) compare_size_result();
      if (hold_count != hold_seen) begin
        hold_seen = hold_count;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (tick % 8) < 3;
      endcase
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end
      results.ready <= rdy;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
        if (gap > 0) begin
          chars.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    chars.valid     <= 1'b1;
    chars.char_code <= c;
    do @(posedge clk); while (!chars.ready);
    if (parse_phase != P_FINISHED) useful_chars++;
    advance_size_parse(c);
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_text(input string s);
    send_chars(s);
    send_char(ASCII_NUL);
  endtask

  // Drop valid and hold until every outstanding result has arrived.
  task automatic wait_drained();
    chars.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_sizes.size() != 0);
  endtask

  task automatic test_single_terms();
    paced = 1'b1;
    send_text("");
    send_text(" \t7q");
    send_text("3 4");
    send_text("3 \015");
    send_text("12k-3");
    send_text("-1k x");
    send_text("1m+2g\v3t 4M5G6T");
  endtask

  task automatic test_saturation();
    paced = 1'b1;
    send_text("-9223372036854775808");
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("-9223372036854775809");
    send_text("8000000T8000000T");
    send_text("-8000000T-8000000T");
    send_text("  -");
    send_text("2k+");
    send_chars("5K");
    send_char(8'hff);
    send_char(ASCII_NUL);
  endtask

  task automatic test_backpressure();
    paced = 1'b0;
    hold_count++;
    repeat (40) send_text("9");
  endtask

  task automatic test_long_strings();
    paced = 1'b0;
    repeat (LONG_RUN) send_char(ASCII_SPACE);
    send_text("x");
    send_char("7");
    repeat (LONG_RUN) send_char(ASCII_SPACE);
    send_text("z");
  endtask

  function automatic logic [7:0] random_blank();
    int p;
    p = $urandom_range(0, 5);
    return (p == 5) ? ASCII_SPACE : ASCII_TAB + 8'(p);
  endfunction

  function automatic logic [7:0] random_suffix();
    case ($urandom_range(0, 7))
      0:       return "k";
      1:       return "K";
      2:       return "m";
      3:       return "M";
      4:       return "g";
      5:       return "G";
      6:       return "t";
      default: return "T";
    endcase
  endfunction

  // Mostly well-formed sums; some with a stray byte inserted, some pure noise.
  task automatic build_random_text();
    int kind;
    int nterms;
    int ndig;
    int sgn;
    int n;
    int t;
    bit sfx;
    text_buf.delete();
    sfx  = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      n = $urandom_range(0, 8);
      repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
    end else begin
      nterms = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(1, 2);
      for (t = 0; t < nterms; t++) begin
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 2)) text_buf.push_back(random_blank());
        sgn = $urandom_range(0, 3);
        if (sgn == 0) text_buf.push_back(ASCII_PLUS);
        else if (sgn == 1) text_buf.push_back(ASCII_MINUS);
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 7);
        repeat (ndig) text_buf.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(random_blank());
        sfx = (t < nterms - 1) || $urandom_range(0, 1);
        if (sfx) text_buf.push_back(random_suffix());
      end
      if (sfx && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
      if (kind >= 70)
        text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom_range(1, 255)));
    end
    text_buf.push_back(ASCII_NUL);
  endtask

  task automatic test_random_strings();
    int start;
    paced = 1'b1;
    start = useful_chars;
    while (useful_chars - start < RANDOM_ITEMS) begin
      build_random_text();
      foreach (text_buf[i]) send_char(text_buf[i]);
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  initial begin
    errors       = 0;
    useful_chars = 0;
    paced        = 1'b0;
    burst_left   = 0;
    clear_parse();
    rst             <= 1'b1;
    chars.valid     <= 1'b0;
    chars.char_code <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_single_terms();
    wait_drained();
    test_saturation();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_long_strings();
    wait_drained();
    test_random_strings();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_sizes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
